@@ rtl/core/rsc_pkg.sv @@
package rsc_pkg;

	localparam int ACC_W       = 64;
	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int BASE_W      = 6;
	localparam int DIGIT_W     = 6;
	localparam int CHAR_W      = 8;
	localparam int PROD_W      = ACC_W + BASE_W;
	localparam int DIV_BITS    = 4;
	localparam int DIV_STEPS   = (ACC_W + DIV_BITS - 1) / DIV_BITS;
	localparam int DIV_W       = DIV_STEPS * DIV_BITS;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_BASE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BASE = CFG_IDX_W'(1);

	localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
	localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
	localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(36);

	localparam logic [CHAR_W-1:0] CHAR_0  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_9  = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_UA = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UZ = 8'h5a;
	localparam logic [CHAR_W-1:0] CHAR_LA = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_LZ = 8'h7a;
	localparam logic [CHAR_W-1:0] DIGIT_TEN = 8'd10;

	typedef struct packed {
		logic [CHAR_W-1:0] in_char;
		logic              in_last;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              out_last;
		logic              overflow;
	} out_item_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic               last;
	} q_item_t;

	typedef enum logic [1:0] {
		ST_ACC,
		ST_DIV,
		ST_RD,
		ST_OUT
	} back_state_t;

endpackage

@@ rtl/core/radix_string_converter.sv @@
// input: a character waits in the two-entry queue until the back end, while accumulating, takes it
// throughput: one character per cycle into the queue while it has room, one multiply-add per cycle while accumulating
// conversion: each result digit comes from one division in the 4-bit-per-cycle divider
// output: each result digit takes one store read and then one output transfer
// reset: control, accumulator and bases (to 10) clear at once, the digit store does not
module radix_string_converter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  rsc_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output rsc_pkg::out_item_t                out_data,
	input  logic                              cfg_we,
	input  logic [rsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rsc_pkg::BASE_W-1:0]        cfg_data
);

	logic [rsc_pkg::BASE_W-1:0] src_base_q;
	logic [rsc_pkg::BASE_W-1:0] tgt_base_q;
	logic                       q_valid;
	logic                       q_ready;
	rsc_pkg::q_item_t           q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_base_q <= rsc_pkg::BASE_RESET;
			tgt_base_q <= rsc_pkg::BASE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == rsc_pkg::CFG_SOURCE_BASE) begin
				src_base_q <= cfg_data;
			end
			if (cfg_index == rsc_pkg::CFG_TARGET_BASE) begin
				tgt_base_q <= cfg_data;
			end
		end
	end

	rsc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_data   (q_data)
	);

	rsc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.source_base (src_base_q),
		.target_base (tgt_base_q),
		.q_valid     (q_valid),
		.q_ready     (q_ready),
		.q_data      (q_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule

@@ rtl/core/rsc_front.sv @@
module rsc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rsc_pkg::in_item_t  in_data,
	output logic               q_valid,
	input  logic               q_ready,
	output rsc_pkg::q_item_t   q_data
);

	function automatic logic [rsc_pkg::DIGIT_W-1:0] char_value(
		input logic [rsc_pkg::CHAR_W-1:0] c);
		logic [rsc_pkg::CHAR_W-1:0] v;
		begin
			v = '0;
			if (c >= rsc_pkg::CHAR_LA && c <= rsc_pkg::CHAR_LZ) begin
				v = c - rsc_pkg::CHAR_LA + rsc_pkg::DIGIT_TEN;
			end else if (c >= rsc_pkg::CHAR_UA && c <= rsc_pkg::CHAR_UZ) begin
				v = c - rsc_pkg::CHAR_UA + rsc_pkg::DIGIT_TEN;
			end else if (c >= rsc_pkg::CHAR_0 && c <= rsc_pkg::CHAR_9) begin
				v = c - rsc_pkg::CHAR_0;
			end
			return v[rsc_pkg::DIGIT_W-1:0];
		end
	endfunction

	rsc_pkg::q_item_t            q_mem_q [rsc_pkg::QDEPTH];
	logic [rsc_pkg::QPTR_W-1:0]  wp_q;
	logic [rsc_pkg::QPTR_W-1:0]  rp_q;
	logic [rsc_pkg::QCNT_W-1:0]  cnt_q;
	logic                        push;
	logic                        pop;

	assign in_ready = (cnt_q != rsc_pkg::QCNT_W'(rsc_pkg::QDEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_data   = q_mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wp_q].digit <= char_value(in_data.in_char);
			q_mem_q[wp_q].last  <= in_data.in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/rsc_div.sv @@
module rsc_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rsc_pkg::ACC_W-1:0]    dividend,
	input  logic [rsc_pkg::BASE_W-1:0]   divisor,
	output logic                         done,
	output logic [rsc_pkg::ACC_W-1:0]    quotient,
	output logic [rsc_pkg::DIGIT_W-1:0]  remainder
);

	logic [rsc_pkg::DIV_W-1:0]     quo_q;
	logic [rsc_pkg::DIGIT_W-1:0]   rem_q;
	logic [rsc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [rsc_pkg::DIV_W-1:0]     quo_nxt;
	logic [rsc_pkg::DIGIT_W-1:0]   rem_nxt;

	// DIV_BITS restoring steps per cycle, msb first
	always_comb begin
		logic [rsc_pkg::DIGIT_W:0] r;
		logic [rsc_pkg::DIV_W-1:0] q;
		r = {1'b0, rem_q};
		q = quo_q;
		for (int i = 0; i < rsc_pkg::DIV_BITS; i++) begin
			r = {r[rsc_pkg::DIGIT_W-1:0], q[rsc_pkg::DIV_W-1]};
			q = {q[rsc_pkg::DIV_W-2:0], 1'b0};
			if (r >= {1'b0, divisor}) begin
				r    = r - {1'b0, divisor};
				q[0] = 1'b1;
			end
		end
		quo_nxt = q;
		rem_nxt = r[rsc_pkg::DIGIT_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= rsc_pkg::DIV_W'(dividend);
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= quo_nxt;
			rem_q <= rem_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rsc_pkg::DIV_CNT_W'(rsc_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q[rsc_pkg::ACC_W-1:0];
	assign remainder = rem_q;

endmodule

@@ rtl/core/rsc_back.sv @@
module rsc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [rsc_pkg::BASE_W-1:0]  source_base,
	input  logic [rsc_pkg::BASE_W-1:0]  target_base,
	input  logic                        q_valid,
	output logic                        q_ready,
	input  rsc_pkg::q_item_t            q_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output rsc_pkg::out_item_t          out_data
);

	function automatic logic [rsc_pkg::BASE_W-1:0] clamp_base(
		input logic [rsc_pkg::BASE_W-1:0] b);
		begin
			if (b < rsc_pkg::BASE_MIN) begin
				return rsc_pkg::BASE_MIN;
			end
			if (b > rsc_pkg::BASE_MAX) begin
				return rsc_pkg::BASE_MAX;
			end
			return b;
		end
	endfunction

	function automatic logic [rsc_pkg::CHAR_W-1:0] digit_char(
		input logic [rsc_pkg::DIGIT_W-1:0] v);
		logic [rsc_pkg::CHAR_W-1:0] w;
		begin
			w = rsc_pkg::CHAR_W'(v);
			if (w < rsc_pkg::DIGIT_TEN) begin
				return w + rsc_pkg::CHAR_0;
			end
			return w + rsc_pkg::CHAR_UA - rsc_pkg::DIGIT_TEN;
		end
	endfunction

	rsc_pkg::back_state_t           state_q;
	rsc_pkg::back_state_t           state_nxt;
	logic [rsc_pkg::ACC_W-1:0]      acc_q;
	logic                           ovf_q;
	logic [rsc_pkg::CNT_W-1:0]      count_q;
	logic [rsc_pkg::DIGIT_W-1:0]    store_q [rsc_pkg::STORE_DEPTH];
	logic [rsc_pkg::DIGIT_W-1:0]    rd_q;
	logic [rsc_pkg::PROD_W-1:0]     sum;
	logic [rsc_pkg::BASE_W-1:0]     sb;
	logic [rsc_pkg::BASE_W-1:0]     tb;
	logic                           take;
	logic                           div_fin;
	logic                           div_more;
	logic [rsc_pkg::ADDR_W-1:0]     rd_addr;
	logic [rsc_pkg::ACC_W-1:0]      div_dividend;
	logic [rsc_pkg::ACC_W-1:0]      div_quo;
	logic [rsc_pkg::DIGIT_W-1:0]    div_rem;
	logic                           div_start;
	logic                           div_done;

	assign sb      = clamp_base(source_base);
	assign tb      = clamp_base(target_base);
	assign sum     = rsc_pkg::PROD_W'(acc_q) * rsc_pkg::PROD_W'(sb)
		+ rsc_pkg::PROD_W'(q_data.digit);
	assign take    = q_valid && q_ready;
	assign rd_addr = rsc_pkg::ADDR_W'(count_q - 1'b1);

	// stop on a zero quotient or a full store
	assign div_fin  = div_done && ((div_quo == '0)
		|| (count_q == rsc_pkg::CNT_W'(rsc_pkg::STORE_DEPTH - 1)));
	assign div_more = div_done && !div_fin;

	rsc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (tb),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rsc_pkg::ST_ACC: begin
				if (take && q_data.last) begin
					state_nxt = rsc_pkg::ST_DIV;
				end
			end
			rsc_pkg::ST_DIV: begin
				if (div_fin) begin
					state_nxt = rsc_pkg::ST_RD;
				end
			end
			rsc_pkg::ST_RD: begin
				state_nxt = rsc_pkg::ST_OUT;
			end
			rsc_pkg::ST_OUT: begin
				if (out_ready) begin
					state_nxt = (count_q == rsc_pkg::CNT_W'(1)) ? rsc_pkg::ST_ACC
						: rsc_pkg::ST_RD;
				end
			end
			default: state_nxt = rsc_pkg::ST_ACC;
		endcase
	end

	always_comb begin
		q_ready       = 1'b0;
		out_valid     = 1'b0;
		div_start     = 1'b0;
		div_dividend  = div_quo;
		unique case (state_q)
			rsc_pkg::ST_ACC: begin
				q_ready       = 1'b1;
				div_start     = q_valid && q_data.last;
				div_dividend  = sum[rsc_pkg::ACC_W-1:0];
			end
			rsc_pkg::ST_DIV: begin
				div_start = div_more;
			end
			rsc_pkg::ST_RD: begin
			end
			rsc_pkg::ST_OUT: begin
				out_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsc_pkg::ST_ACC;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			count_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == rsc_pkg::ST_ACC && take) begin
				acc_q <= q_data.last ? '0 : sum[rsc_pkg::ACC_W-1:0];
				if (sum[rsc_pkg::PROD_W-1:rsc_pkg::ACC_W] != '0) begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == rsc_pkg::ST_DIV && div_done) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == rsc_pkg::ST_OUT && out_ready) begin
				count_q <= count_q - 1'b1;
				if (count_q == rsc_pkg::CNT_W'(1)) begin
					ovf_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rsc_pkg::ST_DIV && div_done) begin
			store_q[count_q[rsc_pkg::ADDR_W-1:0]] <= div_rem;
		end
		if (state_q == rsc_pkg::ST_RD) begin
			rd_q <= store_q[rd_addr];
		end
	end

	assign out_data.out_char = digit_char(rd_q);
	assign out_data.out_last = (count_q == rsc_pkg::CNT_W'(1));
	assign out_data.overflow = ovf_q;

endmodule

@@ tb/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rsc_pkg::*;

	localparam int RANDOM_CHARS  = 100;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 40;
	localparam int QUIET_LIMIT   = 6000;
	localparam int PRINT_CAP     = 40;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	in_item_t           in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	out_item_t          out_data;
	logic               cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BASE_W-1:0]  cfg_data = '0;

	// predictor state
	logic [BASE_W-1:0]  src_base = BASE_RESET;
	logic [BASE_W-1:0]  tgt_base = BASE_RESET;
	logic [ACC_W-1:0]   model_acc = '0;
	logic               model_ovf = 1'b0;
	out_item_t          expected_digits[$];

	logic               idle_on = 1'b1;
	int                 stall_left = 0;
	int                 quiet_cycles = 0;
	int                 mismatches = 0;

	radix_string_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [BASE_W-1:0] clamp_radix(input logic [BASE_W-1:0] b);
		if (b < BASE_MIN) return BASE_MIN;
		if (b > BASE_MAX) return BASE_MAX;
		return b;
	endfunction

	function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] v);
		if (v < DIGIT_TEN) return CHAR_0 + CHAR_W'(v);
		return CHAR_UA + CHAR_W'(v) - DIGIT_TEN;
	endfunction

	function automatic logic [BASE_W-1:0] pick_base();
		logic [BASE_W-1:0] extremes[6];
		extremes = '{6'd0, 6'd1, 6'd2, 6'd36, 6'd37, 6'd63};
		if ($urandom_range(0, 4) == 0) return extremes[$urandom_range(0, 5)];
		return BASE_W'($urandom_range(2, 36));
	endfunction

	task automatic report_mismatch(input string what, input logic [CHAR_W-1:0] got,
		input logic [CHAR_W-1:0] want);
		if (mismatches < PRINT_CAP)
			$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// accumulate one character; on the last one convert and queue the digits
	task automatic predict_char(input logic [CHAR_W-1:0] ch, input logic last);
		logic [DIGIT_W-1:0] d;
		logic [BASE_W-1:0]  b;
		logic [BASE_W-1:0]  t;
		logic [2*ACC_W-1:0] wide;
		logic [ACC_W-1:0]   v;
		logic [DIGIT_W-1:0] digs[$];
		int                 i;
		out_item_t          item;
		b = clamp_radix(src_base);
		if (ch >= CHAR_LA && ch <= CHAR_LZ) d = DIGIT_W'(ch - CHAR_LA + DIGIT_TEN);
		else if (ch >= CHAR_UA && ch <= CHAR_UZ) d = DIGIT_W'(ch - CHAR_UA + DIGIT_TEN);
		else if (ch >= CHAR_0 && ch <= CHAR_9) d = DIGIT_W'(ch - CHAR_0);
		else d = '0;
		wide = {{ACC_W{1'b0}}, model_acc} * b + d;
		if (wide[2*ACC_W-1:ACC_W] != '0) model_ovf = 1'b1;
		model_acc = wide[ACC_W-1:0];
		if (!last) return;
		t = clamp_radix(tgt_base);
		v = model_acc;
		if (v == '0) digs.push_back('0);
		while (v != '0 && digs.size() < STORE_DEPTH) begin
			digs.push_back(DIGIT_W'(v % t));
			v = v / t;
		end
		for (i = digs.size(); i > 0; i--) begin
			item.out_char = ascii_of(digs[i-1]);
			item.out_last = (i == 1);
			item.overflow = model_ovf;
			expected_digits.push_back(item);
		end
		model_acc = '0;
		model_ovf = 1'b0;
	endtask

	task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_data <= '{in_char: ch, in_last: last};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_char(ch, last);
	endtask

	task automatic send_string(input string s);
		int k;
		for (k = 0; k < s.len(); k++) send_char(CHAR_W'(s[k]), k == s.len() - 1);
	endtask

	task automatic drain_output();
		in_valid <= 1'b0;
		while (expected_digits.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_bases(input logic [BASE_W-1:0] src, input logic [BASE_W-1:0] tgt);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SOURCE_BASE;
		cfg_data <= src;
		@(posedge clk);
		cfg_index <= CFG_TARGET_BASE;
		cfg_data <= tgt;
		@(posedge clk);
		cfg_we <= 1'b0;
		src_base = src;
		tgt_base = tgt;
	endtask

	// letter and digit range edges, unknown characters, digits above the radix
	task automatic test_char_map();
		send_char(8'hff, 1'b0);
		send_string("09azAZ/:@[`{");
	endtask

	task automatic test_zero_value();
		send_char(CHAR_0, 1'b1);
	endtask

	// out-of-range base registers clamp; 13 top digits in radix 36 wrap 64 bits
	task automatic test_overflow();
		drain_output();
		set_bases(6'd63, 6'd1);
		send_string("zzzzzzzzzzzzz");
	endtask

	task automatic test_random_numbers();
		int                 sent;
		int                 nums;
		int                 len;
		int                 k;
		logic               noisy;
		logic [BASE_W-1:0]  b;
		logic [DIGIT_W-1:0] v;
		logic [CHAR_W-1:0]  ch;
		sent = 0;
		nums = 0;
		while (sent < RANDOM_CHARS) begin
			if (nums % 4 == 0) begin
				drain_output();
				set_bases(pick_base(), pick_base());
			end
			idle_on <= (sent < RANDOM_CHARS * 3 / 4) && ($urandom_range(0, 3) != 0);
			b = clamp_radix(src_base);
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 10);
			noisy = ($urandom_range(0, 7) == 0);
			for (k = 0; k < len; k++) begin
				if (noisy || $urandom_range(0, 11) == 0) begin
					ch = CHAR_W'($urandom_range(0, 255));
				end else begin
					v = DIGIT_W'($urandom_range(0, b - 1));
					ch = ascii_of(v);
					if (v >= DIGIT_TEN && $urandom_range(0, 1) == 1) ch = ch + (CHAR_LA - CHAR_UA);
				end
				send_char(ch, k == len - 1);
				sent++;
			end
			nums++;
		end
	endtask

	// receiver stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 13);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// compare each output transfer with the oldest queued digit
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_digits.size() == 0) begin
				report_mismatch("unexpected digit", out_data.out_char, '0);
			end else begin
				want = expected_digits.pop_front();
				if (out_data.out_char !== want.out_char)
					report_mismatch("out_char", out_data.out_char, want.out_char);
				if (out_data.out_last !== want.out_last)
					report_mismatch("out_last", CHAR_W'(out_data.out_last), CHAR_W'(want.out_last));
				if (out_data.overflow !== want.overflow)
					report_mismatch("overflow", CHAR_W'(out_data.overflow), CHAR_W'(want.overflow));
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_char_map();
		test_zero_value();
		test_overflow();
		test_random_numbers();
		drain_output();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/rsc_pkg.sv
rtl/core/rsc_front.sv
rtl/core/rsc_div.sv
rtl/core/rsc_back.sv
rtl/core/radix_string_converter.sv
tb/tb.sv
